### rtl/overlay_occupancy_grid_cull_defines.svh
// assertion macros shared by the overlay occupancy grid cull rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef OVERLAY_OCCUPANCY_GRID_CULL_DEFINES_SVH
`define OVERLAY_OCCUPANCY_GRID_CULL_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define OGC_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define OGC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ogc_pkg.sv
// shared types and constants for the overlay occupancy grid cull
// no dependencies
`default_nettype none

package ogc_pkg;

   localparam int CELL_WIDTH   = 20;
   localparam int CELL_HEIGHT  = 10;
   localparam int GRID_COLUMNS = 16;
   localparam int GRID_ROWS    = 20;

   localparam int EDGE_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = EDGE_W - FRAC_BITS;

   // reciprocal of the cell size, rounded up, scaled by 2^RECIP_SHIFT
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = COORD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'((64'd1 << RECIP_SHIFT) / CELL_WIDTH + 64'd1);
   localparam logic [RECIP_W-1:0] RECIP_Y =
      RECIP_W'((64'd1 << RECIP_SHIFT) / CELL_HEIGHT + 64'd1);

   localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int WORD_W = 2 * GRID_COLUMNS;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic FUNC_CLEAR   = 1'b0;
   localparam logic FUNC_BOX     = 1'b1;
   localparam logic PLANE_MARKER = 1'b0;
   localparam logic PLANE_TAG    = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_BOX   = 2'd1,
      CMD_SKIP  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    plane;
      logic [GRID_COLUMNS-1:0] col_mask;
      logic [ROW_W-1:0]        row_first;
      logic [ROW_W-1:0]        row_last;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/ogc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ogc_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/ogc_front.sv
// front end: accepts request beats, turns box edges into cell ranges
// depends on ogc_pkg
`default_nettype none

module ogc_front import ogc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_func,
   input  wire logic                     req_plane,
   input  wire logic signed [EDGE_W-1:0] req_box_left,
   input  wire logic signed [EDGE_W-1:0] req_box_right,
   input  wire logic signed [EDGE_W-1:0] req_box_top,
   input  wire logic signed [EDGE_W-1:0] req_box_bottom,
   input  wire logic                     sweeping,
   input  wire logic                     q_full,
   output logic                          q_push,
   output cmd_type                       q_push_cmd
);

   localparam int EDGE_L = 0;
   localparam int EDGE_R = 1;
   localparam int EDGE_T = 2;
   localparam int EDGE_B = 3;

   // integer part of |v|, i.e. floor(|v| / 2^16)
   function automatic logic [COORD_W-1:0] edge_mag(input logic [EDGE_W-1:0] v);
      logic [COORD_W-1:0] m;
      if (v[EDGE_W-1]) begin
         m = ~v[EDGE_W-1:FRAC_BITS] + COORD_W'(v[FRAC_BITS-1:0] == '0);
      end else begin
         m = v[EDGE_W-1:FRAC_BITS];
      end
      return m;
   endfunction

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_func_ff;
   logic                    s1_plane_ff;
   logic [3:0]              s1_neg_ff;
   logic [COORD_W-1:0]      s1_quot_ff [4];

   logic [EDGE_W-1:0]       edge_raw [4];
   logic [RECIP_W-1:0]      edge_recip [4];
   logic [PROD_W-1:0]       edge_prod [4];
   logic                    req_fire;

   logic [COORD_W-1:0]      x_first, x_last, y_first, y_last;
   logic                    x_empty, y_empty;
   logic [GRID_COLUMNS-1:0] col_mask;

   assign edge_raw[EDGE_L]   = req_box_left;
   assign edge_raw[EDGE_R]   = req_box_right;
   assign edge_raw[EDGE_T]   = req_box_top;
   assign edge_raw[EDGE_B]   = req_box_bottom;
   assign edge_recip[EDGE_L] = RECIP_X;
   assign edge_recip[EDGE_R] = RECIP_X;
   assign edge_recip[EDGE_T] = RECIP_Y;
   assign edge_recip[EDGE_B] = RECIP_Y;

   // magnitude divided by the cell size through its reciprocal
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         edge_prod[i] = PROD_W'(edge_mag(edge_raw[i])) * PROD_W'(edge_recip[i]);
      end
   end

   assign q_push    = s1_valid_ff && !q_full;
   assign req_ready = !sweeping && (!s1_valid_ff || !q_full);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff  <= req_func;
         s1_plane_ff <= req_plane;
         for (int i = 0; i < 4; i++) begin
            s1_neg_ff[i]  <= edge_raw[i][EDGE_W-1];
            s1_quot_ff[i] <= edge_prod[i][RECIP_SHIFT +: COORD_W];
         end
      end
   end

   // clamp to the grid; a far edge one cell or more below zero empties the range
   always_comb begin
      x_first = s1_neg_ff[EDGE_L] ? '0 : s1_quot_ff[EDGE_L];
      x_last  = (s1_quot_ff[EDGE_R] > COORD_W'(GRID_COLUMNS - 1)) ?
                COORD_W'(GRID_COLUMNS - 1) : s1_quot_ff[EDGE_R];
      x_empty = (s1_neg_ff[EDGE_R] && (s1_quot_ff[EDGE_R] != '0)) || (x_first > x_last);
      y_first = s1_neg_ff[EDGE_T] ? '0 : s1_quot_ff[EDGE_T];
      y_last  = (s1_quot_ff[EDGE_B] > COORD_W'(GRID_ROWS - 1)) ?
                COORD_W'(GRID_ROWS - 1) : s1_quot_ff[EDGE_B];
      y_empty = (s1_neg_ff[EDGE_B] && (s1_quot_ff[EDGE_B] != '0)) || (y_first > y_last);
      for (int c = 0; c < GRID_COLUMNS; c++) begin
         col_mask[c] = (COORD_W'(c) >= x_first) && (COORD_W'(c) <= x_last);
      end
   end

   always_comb begin
      q_push_cmd.plane     = s1_plane_ff;
      q_push_cmd.col_mask  = col_mask;
      q_push_cmd.row_first = y_first[ROW_W-1:0];
      q_push_cmd.row_last  = y_last[ROW_W-1:0];
      if (s1_func_ff == FUNC_CLEAR) begin
         q_push_cmd.kind = CMD_CLEAR;
      end else if (x_empty || y_empty) begin
         q_push_cmd.kind = CMD_SKIP;
      end else begin
         q_push_cmd.kind = CMD_BOX;
      end
   end

endmodule

`default_nettype wire

### rtl/ogc_queue.sv
// short command queue between the front end and the grid walker
// depends on ogc_pkg
`default_nettype none

module ogc_queue import ogc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty
);

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/ogc_back.sv
// grid walker: row ram of both occupancy planes, clears and claims rows
// depends on ogc_pkg, ogc_ram and the assertion macro header
`default_nettype none
`include "overlay_occupancy_grid_cull_defines.svh"

module ogc_back import ogc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         sweeping,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_in_front
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_POST  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [ROW_W-1:0]        row_rd_ff, row_rd_in;
   logic [ROW_W-1:0]        row_wr_ff, row_wr_in;
   logic [ROW_W-1:0]        row_last_ff, row_last_in;
   logic                    issue_done_ff, issue_done_in;
   logic                    pend_ff, pend_in;
   logic                    post_ff, post_in;
   logic                    init_ff, init_in;
   logic                    all_mine_ff, all_mine_in;
   logic                    result_ff, result_in;
   logic                    plane_ff, plane_in;
   logic [GRID_COLUMNS-1:0] mask_ff, mask_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_in_front_ff, rsp_in_front_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0]        ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]       ram_wr_data, ram_rd_data;

   logic [GRID_COLUMNS-1:0] word_lo, word_hi, word_sel, word_new;
   logic                    hit;

   ogc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GRID_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // claim free cells of the box columns on the box plane, flag claimed ones
   always_comb begin
      word_lo  = ram_rd_data[GRID_COLUMNS-1:0];
      word_hi  = ram_rd_data[WORD_W-1:GRID_COLUMNS];
      word_sel = (plane_ff == PLANE_TAG) ? word_hi : word_lo;
      hit      = |(word_sel & mask_ff);
      word_new = word_sel | mask_ff;
   end

   assign ram_rd_en   = (state_ff == ST_WALK) && !issue_done_ff;
   assign ram_rd_addr = row_rd_ff;
   assign q_pop       = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = row_wr_ff;
      ram_wr_data = (plane_ff == PLANE_TAG) ? {word_new, word_lo} : {word_hi, word_new};
      if (state_ff == ST_SWEEP) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = row_rd_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_WALK) begin
         ram_wr_en = pend_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      row_rd_in       = row_rd_ff;
      row_wr_in       = row_wr_ff;
      row_last_in     = row_last_ff;
      issue_done_in   = issue_done_ff;
      pend_in         = pend_ff;
      post_in         = post_ff;
      init_in         = init_ff;
      all_mine_in     = all_mine_ff;
      result_in       = result_ff;
      plane_in        = plane_ff;
      mask_in         = mask_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in_front_in = rsp_in_front_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_head.kind)
                  CMD_CLEAR: begin
                     row_rd_in = '0;
                     post_in   = 1'b1;
                     result_in = 1'b0;
                     state_in  = ST_SWEEP;
                  end
                  CMD_SKIP: begin
                     result_in = 1'b1;
                     state_in  = ST_POST;
                  end
                  CMD_BOX: begin
                     row_rd_in     = q_head.row_first;
                     row_last_in   = q_head.row_last;
                     plane_in      = q_head.plane;
                     mask_in       = q_head.col_mask;
                     issue_done_in = 1'b0;
                     pend_in       = 1'b0;
                     all_mine_in   = 1'b1;
                     state_in      = ST_WALK;
                  end
                  default: begin
                     result_in = 1'b1;
                     state_in  = ST_POST;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (row_rd_ff == ROW_W'(GRID_ROWS - 1)) begin
               init_in  = 1'b0;
               state_in = post_ff ? ST_POST : ST_IDLE;
            end else begin
               row_rd_in = row_rd_ff + 1'b1;
            end
         end
         ST_WALK: begin
            // read of the next row overlaps the write-back of the previous one
            if (!issue_done_ff) begin
               pend_in   = 1'b1;
               row_wr_in = row_rd_ff;
               if (row_rd_ff == row_last_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  row_rd_in = row_rd_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && hit) begin
               all_mine_in = 1'b0;
            end
            if (issue_done_ff && pend_ff) begin
               result_in = all_mine_ff && !hit;
               state_in  = ST_POST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in_front_in = result_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_rd_ff     <= '0;
         post_ff       <= 1'b0;
         init_ff       <= 1'b1;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_rd_ff     <= row_rd_in;
         post_ff       <= post_in;
         init_ff       <= init_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_wr_ff       <= row_wr_in;
      row_last_ff     <= row_last_in;
      all_mine_ff     <= all_mine_in;
      result_ff       <= result_in;
      plane_ff        <= plane_in;
      mask_ff         <= mask_in;
      rsp_in_front_ff <= rsp_in_front_in;
   end

   assign sweeping     = init_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_front = rsp_in_front_ff;

   `OGC_ASSERT_IMPL(a_no_row_clash, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "row read and write hit the same row")
   `OGC_ASSERT_IMPL(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !ram_wr_en, "grid written while idle")
   `OGC_ASSERT_IMPL(a_walk_in_range, clock, reset, (state_ff == ST_WALK) && pend_ff, row_wr_ff <= row_last_ff, "write-back past the last row of the box")
   `OGC_ASSERT_NEXT(a_post_loads, clock, reset, (state_ff == ST_POST) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded from post")

endmodule

`default_nettype wire

### rtl/overlay_occupancy_grid_cull.sv
// Overlay occupancy grid cull. Each request beat is either a clear (func 0) or a box
// (func 1) with signed 16.16 edges and a plane bit; each gives one response beat,
// in_front, in request order. A box covering r grid rows passes the grid walker as
// command pop, a walk of one row per cycle through the separate read and write ports
// of the row ram with registered read data, and result load, behind a registered
// edge-to-cell stage and a two-entry command queue; the row walk sets the rate. A clear
// writes all GRID_ROWS rows (20 row writes plus pop and load). After reset the grid
// is cleared by a pass over all 20 rows during which req_ready stays low.
// depends on ogc_pkg, ogc_front, ogc_queue, ogc_back
`default_nettype none

module overlay_occupancy_grid_cull import ogc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_func,
   input  wire logic                     req_plane,
   input  wire logic signed [EDGE_W-1:0] req_box_left,
   input  wire logic signed [EDGE_W-1:0] req_box_right,
   input  wire logic signed [EDGE_W-1:0] req_box_top,
   input  wire logic signed [EDGE_W-1:0] req_box_bottom,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_in_front
);

   logic    q_push, q_full, q_pop, q_empty, sweeping;
   cmd_type q_push_cmd, q_head;

   ogc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_plane      (req_plane),
      .req_box_left   (req_box_left),
      .req_box_right  (req_box_right),
      .req_box_top    (req_box_top),
      .req_box_bottom (req_box_bottom),
      .sweeping       (sweeping),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_cmd     (q_push_cmd)
   );

   ogc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   ogc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .sweeping     (sweeping),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_in_front (rsp_in_front)
   );

endmodule

`default_nettype wire
